/* sv/hkr_pkg.sv */
// Shared types, keycode constants and character tables for the HID keyboard converter.
package hkr_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_SLOTS = 6;
    localparam int unsigned IN_DATA_W = BYTE_W * (MAX_SLOTS + 1);
    localparam int unsigned CFG_ADDR_W = 2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_ENTER_CHAR      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ARROW_UP_CHAR   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ARROW_DOWN_CHAR = 2'd2;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] ENTER_CHAR_RST      = 8'd13;
    localparam logic [BYTE_W-1:0] ARROW_UP_CHAR_RST   = 8'd17;
    localparam logic [BYTE_W-1:0] ARROW_DOWN_CHAR_RST = 8'd18;

    // Left shift (bit 1) or right shift (bit 5)
    localparam logic [BYTE_W-1:0] SHIFT_MASK = 8'h22;

    // HID usage codes
    localparam logic [BYTE_W-1:0] KEY_NONE       = 8'h00;
    localparam logic [BYTE_W-1:0] KEY_A          = 8'h04;
    localparam logic [BYTE_W-1:0] KEY_Z          = 8'h1D;
    localparam logic [BYTE_W-1:0] KEY_1          = 8'h1E;
    localparam logic [BYTE_W-1:0] KEY_0          = 8'h27;
    localparam logic [BYTE_W-1:0] KEY_ENTER      = 8'h28;
    localparam logic [BYTE_W-1:0] KEY_BACKSPACE  = 8'h2A;
    localparam logic [BYTE_W-1:0] KEY_SPACE      = 8'h2C;
    localparam logic [BYTE_W-1:0] KEY_ARROW_DOWN = 8'h51;
    localparam logic [BYTE_W-1:0] KEY_ARROW_UP   = 8'h52;

    // Characters
    localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;

    localparam int unsigned DIGITS = 10;
    localparam logic [BYTE_W-1:0] DIGIT_PLAIN [DIGITS] = '{
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30
    };
    localparam logic [BYTE_W-1:0] DIGIT_SHIFT [DIGITS] = '{
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29
    };

    // Programmable characters
    typedef struct packed {
        logic [BYTE_W-1:0] enter_char;
        logic [BYTE_W-1:0] arrow_up_char;
        logic [BYTE_W-1:0] arrow_down_char;
    } cfg_t;

    // One converted report
    typedef struct packed {
        logic              key_valid;
        logic [BYTE_W-1:0] key_char;
    } result_t;

endpackage

/* sv/hkr_keymap.sv */
// Keycode to character lookup for one slot.
module hkr_keymap (
    input  logic [hkr_pkg::BYTE_W-1:0] code,
    input  logic                       shifted,
    input  hkr_pkg::cfg_t              cfg,
    output logic [hkr_pkg::BYTE_W-1:0] key_char
);

    logic [hkr_pkg::BYTE_W-1:0] letter_ofs;
    logic [hkr_pkg::BYTE_W-1:0] digit_ofs;
    logic [3:0]                 digit_idx;

    assign letter_ofs = code - hkr_pkg::KEY_A;
    assign digit_ofs  = code - hkr_pkg::KEY_1;
    assign digit_idx  = digit_ofs[3:0];

    // Letters, digits, then the single-code keys
    always_comb begin
        key_char = hkr_pkg::CHAR_NUL;
        if (code >= hkr_pkg::KEY_A && code <= hkr_pkg::KEY_Z) begin
            key_char = (shifted ? hkr_pkg::CHAR_UPPER_A : hkr_pkg::CHAR_LOWER_A) + letter_ofs;
        end else if (code >= hkr_pkg::KEY_1 && code <= hkr_pkg::KEY_0) begin
            key_char = shifted ? hkr_pkg::DIGIT_SHIFT[digit_idx]
                               : hkr_pkg::DIGIT_PLAIN[digit_idx];
        end else begin
            case (code)
                hkr_pkg::KEY_ENTER:      key_char = cfg.enter_char;
                hkr_pkg::KEY_BACKSPACE:  key_char = hkr_pkg::CHAR_BACKSPACE;
                hkr_pkg::KEY_SPACE:      key_char = hkr_pkg::CHAR_SPACE;
                // Arrow codes are crossed on purpose
                hkr_pkg::KEY_ARROW_DOWN: key_char = cfg.arrow_up_char;
                hkr_pkg::KEY_ARROW_UP:   key_char = cfg.arrow_down_char;
                default:                 key_char = hkr_pkg::CHAR_NUL;
            endcase
        end
    end

endmodule

/* sv/hkr_report_eval.sv */
// New-press detection against the previous report and last-key selection.
module hkr_report_eval #(
    parameter int unsigned KEY_SLOTS = 6
) (
    input  logic [hkr_pkg::BYTE_W-1:0]                modifier_bits,
    input  logic [KEY_SLOTS-1:0][hkr_pkg::BYTE_W-1:0] keys,
    input  logic [KEY_SLOTS-1:0][hkr_pkg::BYTE_W-1:0] prev_keys,
    input  hkr_pkg::cfg_t                             cfg,
    output hkr_pkg::result_t                          result
);

    logic                                      shifted;
    logic [KEY_SLOTS-1:0]                      new_press;
    logic [KEY_SLOTS-1:0][hkr_pkg::BYTE_W-1:0] slot_char;

    assign shifted = |(modifier_bits & hkr_pkg::SHIFT_MASK);

    // Per slot: compare against every stored code, then look up the character
    for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
        logic [KEY_SLOTS-1:0] hit;

        for (genvar j = 0; j < KEY_SLOTS; j++) begin : g_cmp
            assign hit[j] = (keys[i] == prev_keys[j]);
        end

        assign new_press[i] = (keys[i] != hkr_pkg::KEY_NONE) && !(|hit);

        hkr_keymap u_keymap (
            .code     (keys[i]),
            .shifted  (shifted),
            .cfg      (cfg),
            .key_char (slot_char[i])
        );
    end

    // Keep the last new press in slot order that maps to a character
    always_comb begin
        result.key_valid = 1'b0;
        result.key_char  = hkr_pkg::CHAR_NUL;
        for (int unsigned i = 0; i < KEY_SLOTS; i++) begin
            if (new_press[i] && slot_char[i] != hkr_pkg::CHAR_NUL) begin
                result.key_valid = 1'b1;
                result.key_char  = slot_char[i];
            end
        end
    end

endmodule

/* sv/hid_keyboard_report_to_ascii_core.sv */
// Top level: input register, report evaluation, result register and config registers.
// A report accepted into the input register moves on to the result register, which presents it on m_*.
// Throughput: one report per cycle; a register advances when empty or when taken.
// The previous-keycode store updates as a report leaves the input register.
// Reset (aresetn low, synchronous): both stages empty, stored keycodes all zero,
// characters back to enter 13, arrow up 17, arrow down 18.
module hid_keyboard_report_to_ascii_core #(
    parameter int unsigned KEY_SLOTS = 6
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [hkr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [hkr_pkg::BYTE_W-1:0]           cfg_wdata,
    // Report input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // modifier_bits [7:0], key_slot_0 [15:8] ... key_slot_5 [55:48]
    input  logic [hkr_pkg::IN_DATA_W-1:0]        s_tdata,
    // Character output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // key_char [7:0]
    output logic [hkr_pkg::BYTE_W-1:0]           m_tdata,
    // key_valid [0]
    output logic                                 m_tuser
);

    hkr_pkg::cfg_t                              cfg_reg;
    hkr_pkg::cfg_t                              cfg_next;

    logic                                       in_valid_reg;
    logic [hkr_pkg::BYTE_W-1:0]                 in_mod_reg;
    logic [KEY_SLOTS-1:0][hkr_pkg::BYTE_W-1:0]  in_keys_reg;
    logic [KEY_SLOTS-1:0][hkr_pkg::BYTE_W-1:0]  in_keys_next;
    logic [KEY_SLOTS-1:0][hkr_pkg::BYTE_W-1:0]  prev_keys_reg;

    logic                                       out_valid_reg;
    hkr_pkg::result_t                           out_reg;
    hkr_pkg::result_t                           eval_result;

    logic                                       out_ready;
    logic                                       in_advance;

    // Unpack the used slots of the incoming report
    for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_unpack
        assign in_keys_next[i] = s_tdata[hkr_pkg::BYTE_W*(i+1) +: hkr_pkg::BYTE_W];
    end

    // Handshake between stages
    assign out_ready  = !out_valid_reg || m_tready;
    assign in_advance = in_valid_reg && out_ready;
    assign s_tready   = !in_valid_reg || out_ready;

    // Decode configuration writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                hkr_pkg::CFG_ENTER_CHAR:      cfg_next.enter_char      = cfg_wdata;
                hkr_pkg::CFG_ARROW_UP_CHAR:   cfg_next.arrow_up_char   = cfg_wdata;
                hkr_pkg::CFG_ARROW_DOWN_CHAR: cfg_next.arrow_down_char = cfg_wdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enter_char      <= hkr_pkg::ENTER_CHAR_RST;
            cfg_reg.arrow_up_char   <= hkr_pkg::ARROW_UP_CHAR_RST;
            cfg_reg.arrow_down_char <= hkr_pkg::ARROW_DOWN_CHAR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Input register: capture a report when the stage is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mod_reg  <= s_tdata[hkr_pkg::BYTE_W-1:0];
            in_keys_reg <= in_keys_next;
        end
    end

    hkr_report_eval #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_eval (
        .modifier_bits (in_mod_reg),
        .keys          (in_keys_reg),
        .prev_keys     (prev_keys_reg),
        .cfg           (cfg_reg),
        .result        (eval_result)
    );

    // Replace the stored keycodes as each report is evaluated
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_keys_reg <= '0;
        end else if (in_advance) begin
            prev_keys_reg <= in_keys_reg;
        end
    end

    // Result register: hold until taken downstream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            out_reg <= eval_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.key_char;
    assign m_tuser  = out_reg.key_valid;

    // A result without a key carries a zero character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == hkr_pkg::CHAR_NUL))
        else $error("key_char nonzero while key_valid is low");

    // A valid key always carries a nonzero character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata != hkr_pkg::CHAR_NUL))
        else $error("key_valid set with zero character");

    // Stored keycodes follow each evaluated report
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_advance |=> (prev_keys_reg == $past(in_keys_reg)))
        else $error("previous keycodes not updated from evaluated report");

    // Input stalls only when both stages are full and the output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("input stalled with room in the pipeline");

endmodule

/* tb/hid_keyboard_report_to_ascii_core_test.sv */
// Self-checking testbench for the HID boot-keyboard report to ASCII converter.
`timescale 1ns / 1ps

module hid_keyboard_report_to_ascii_core_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_REPORTS = 540;
    // Write index past the last register; the block must ignore it
    localparam logic [hkr_pkg::CFG_ADDR_W-1:0] CFG_NO_REG = 2'd3;
    // Digit row, key 1 first, plain and shifted
    localparam logic [79:0] DIGIT_ROW_PLAIN = "1234567890";
    localparam logic [79:0] DIGIT_ROW_SHIFT = "!@#$%^&*()";
    localparam logic [hkr_pkg::BYTE_W-1:0] BS_CHAR = 8'h08;
    localparam logic [hkr_pkg::BYTE_W-1:0] SP_CHAR = 8'h20;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [hkr_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [hkr_pkg::BYTE_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [hkr_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [hkr_pkg::BYTE_W-1:0]      m_tdata;
    logic                            m_tuser;

    // Predictor state: keycodes of the last accepted report and the characters
    logic [hkr_pkg::MAX_SLOTS-1:0][hkr_pkg::BYTE_W-1:0] held_codes = '0;
    logic [hkr_pkg::BYTE_W-1:0] enter_chr = hkr_pkg::ENTER_CHAR_RST;
    logic [hkr_pkg::BYTE_W-1:0] up_chr    = hkr_pkg::ARROW_UP_CHAR_RST;
    logic [hkr_pkg::BYTE_W-1:0] down_chr  = hkr_pkg::ARROW_DOWN_CHAR_RST;

    hkr_pkg::result_t expected_keys [$];
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int cycles = 0;
    int errors = 0;
    int n_reports = 0;
    int n_results = 0;
    int n_chars = 0;
    int n_writes = 0;

    hid_keyboard_report_to_ascii_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_keys.size());
            $display("hid_keyboard_report_to_ascii_core regression: fail");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d, cycle %0d)",
                 what, got, want, n_results, cycles);
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        hkr_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_keys.size() == 0) begin
                report_mismatch("unexpected result", {m_tuser, m_tdata}, 0);
            end else begin
                want = expected_keys.pop_front();
                if (m_tuser !== want.key_valid)
                    report_mismatch("key_valid", m_tuser, want.key_valid);
                if (m_tdata !== want.key_char)
                    report_mismatch("key_char", m_tdata, want.key_char);
                if (want.key_valid)
                    n_chars++;
            end
            n_results++;
        end
    end

    function automatic logic [hkr_pkg::BYTE_W-1:0] char_for(
        input logic [hkr_pkg::BYTE_W-1:0] code, input logic shifted);
        int idx;
        if (code >= hkr_pkg::KEY_A && code <= hkr_pkg::KEY_Z)
            return (shifted ? "A" : "a") + (code - hkr_pkg::KEY_A);
        if (code >= hkr_pkg::KEY_1 && code <= hkr_pkg::KEY_0) begin
            idx = code - hkr_pkg::KEY_1;
            return shifted ? DIGIT_ROW_SHIFT[8*(9-idx) +: 8] : DIGIT_ROW_PLAIN[8*(9-idx) +: 8];
        end
        // The arrow registers are crossed with respect to the key names
        case (code)
            hkr_pkg::KEY_ENTER:      return enter_chr;
            hkr_pkg::KEY_BACKSPACE:  return BS_CHAR;
            hkr_pkg::KEY_SPACE:      return SP_CHAR;
            hkr_pkg::KEY_ARROW_DOWN: return up_chr;
            hkr_pkg::KEY_ARROW_UP:   return down_chr;
            default:                 return hkr_pkg::CHAR_NUL;
        endcase
    endfunction

    // Last new press with a character, judged against the previous report
    function automatic hkr_pkg::result_t decode_report(
        input logic [hkr_pkg::BYTE_W-1:0] mods,
        input logic [hkr_pkg::MAX_SLOTS-1:0][hkr_pkg::BYTE_W-1:0] codes);
        hkr_pkg::result_t r;
        logic shifted;
        logic held;
        logic [hkr_pkg::BYTE_W-1:0] c;
        r = '0;
        shifted = (mods & hkr_pkg::SHIFT_MASK) != 0;
        for (int i = 0; i < hkr_pkg::MAX_SLOTS; i++) begin
            held = 1'b0;
            for (int j = 0; j < hkr_pkg::MAX_SLOTS; j++)
                if (held_codes[j] == codes[i])
                    held = 1'b1;
            if (codes[i] != hkr_pkg::KEY_NONE && !held) begin
                c = char_for(codes[i], shifted);
                if (c != hkr_pkg::CHAR_NUL) begin
                    r.key_valid = 1'b1;
                    r.key_char = c;
                end
            end
        end
        held_codes = codes;
        return r;
    endfunction

    function automatic logic [hkr_pkg::MAX_SLOTS-1:0][hkr_pkg::BYTE_W-1:0] key_row(
        input logic [hkr_pkg::BYTE_W-1:0] s0, s1, s2, s3, s4, s5);
        return {s5, s4, s3, s2, s1, s0};
    endfunction

    // Offer one report; return at the edge that accepts it
    task automatic send_report(input logic [hkr_pkg::BYTE_W-1:0] mods,
        input logic [hkr_pkg::MAX_SLOTS-1:0][hkr_pkg::BYTE_W-1:0] codes);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {codes, mods};
        do @(posedge aclk); while (!s_tready);
        expected_keys.push_back(decode_report(mods, codes));
        n_reports++;
    endtask

    // Hold the input idle until every prediction has been matched
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_keys.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [hkr_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [hkr_pkg::BYTE_W-1:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        case (idx)
            hkr_pkg::CFG_ENTER_CHAR:      enter_chr = value;
            hkr_pkg::CFG_ARROW_UP_CHAR:   up_chr = value;
            hkr_pkg::CFG_ARROW_DOWN_CHAR: down_chr = value;
            default: ;
        endcase
        n_writes++;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Table corners, shift bits, held keys, repeats and unmapped codes at reset settings
    task automatic test_key_table();
        send_report(8'h00, key_row(hkr_pkg::KEY_A, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'h00, '0);
        send_report(8'h02, key_row(hkr_pkg::KEY_Z, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'h20, key_row(hkr_pkg::KEY_A, hkr_pkg::KEY_Z, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'hDD, key_row(hkr_pkg::KEY_1, hkr_pkg::KEY_0, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'hFF, key_row(hkr_pkg::KEY_1, hkr_pkg::KEY_0, 8'h26,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'h00, '0);
        send_report(8'h22, key_row(hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_1));
        send_report(8'h00, key_row(hkr_pkg::KEY_ENTER, hkr_pkg::KEY_BACKSPACE,
                                   hkr_pkg::KEY_SPACE, hkr_pkg::KEY_ARROW_DOWN,
                                   hkr_pkg::KEY_ARROW_UP, 8'h03));
        send_report(8'h00, key_row(hkr_pkg::KEY_ENTER, hkr_pkg::KEY_BACKSPACE,
                                   hkr_pkg::KEY_SPACE, hkr_pkg::KEY_ARROW_DOWN,
                                   hkr_pkg::KEY_ARROW_UP, 8'h03));
        send_report(8'h00, '0);
        send_report(8'h00, key_row(hkr_pkg::KEY_SPACE, 8'h80, 8'hFF, 8'h2B, 8'h7F, 8'h01));
        send_report(8'h00, key_row(hkr_pkg::KEY_BACKSPACE, hkr_pkg::KEY_BACKSPACE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'h02, key_row(hkr_pkg::KEY_ENTER, hkr_pkg::KEY_ENTER,
                                   hkr_pkg::KEY_BACKSPACE, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'h20, key_row(hkr_pkg::KEY_ARROW_DOWN, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'hFF, '1);
        send_report(8'h00, key_row(8'h80, 8'h80, 8'hC5, 8'h52, 8'h51, 8'h28));
    endtask

    // Zeroed and saturated registers, plus a write to the unused index
    task automatic test_char_registers();
        wait_idle();
        write_reg(hkr_pkg::CFG_ENTER_CHAR, 8'h00);
        write_reg(hkr_pkg::CFG_ARROW_UP_CHAR, 8'hFF);
        write_reg(hkr_pkg::CFG_ARROW_DOWN_CHAR, 8'h00);
        write_reg(CFG_NO_REG, 8'h55);
        send_report(8'h00, '0);
        send_report(8'h00, key_row(hkr_pkg::KEY_ENTER, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'h00, key_row(hkr_pkg::KEY_ARROW_DOWN, hkr_pkg::KEY_ARROW_UP,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        send_report(8'h00, '0);
        send_report(8'h00, key_row(hkr_pkg::KEY_A, hkr_pkg::KEY_ENTER, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
        wait_idle();
        write_reg(hkr_pkg::CFG_ENTER_CHAR, 8'hFF);
        write_reg(hkr_pkg::CFG_ARROW_UP_CHAR, 8'h00);
        write_reg(hkr_pkg::CFG_ARROW_DOWN_CHAR, 8'hFF);
        write_reg(CFG_NO_REG, 8'h00);
        send_report(8'h00, '0);
        send_report(8'h00, key_row(hkr_pkg::KEY_ARROW_UP, hkr_pkg::KEY_ENTER,
                                   hkr_pkg::KEY_ARROW_DOWN, hkr_pkg::KEY_NONE,
                                   hkr_pkg::KEY_NONE, hkr_pkg::KEY_NONE));
    endtask

    // Typing-like report stream: mostly held keys and mapped presses, some noise
    task automatic test_random_typing(input int n, input int src_pct, input int snk_pct,
                                      input logic [hkr_pkg::BYTE_W-1:0] ent, up, down,
                                      input bit pause_midway);
        logic [hkr_pkg::MAX_SLOTS-1:0][hkr_pkg::BYTE_W-1:0] codes;
        logic [hkr_pkg::BYTE_W-1:0] mods;
        int r;
        wait_idle();
        write_reg(hkr_pkg::CFG_ENTER_CHAR, ent);
        write_reg(hkr_pkg::CFG_ARROW_UP_CHAR, up);
        write_reg(hkr_pkg::CFG_ARROW_DOWN_CHAR, down);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0:       mods = 8'h00;
                1:       mods = 8'h02;
                2:       mods = 8'h20;
                default: mods = 8'($urandom_range(255));
            endcase
            if ($urandom_range(9) == 0) begin
                for (int i = 0; i < hkr_pkg::MAX_SLOTS; i++)
                    codes[i] = 8'($urandom_range(255));
            end else begin
                for (int i = 0; i < hkr_pkg::MAX_SLOTS; i++) begin
                    r = $urandom_range(99);
                    if (r < 45)
                        codes[i] = held_codes[i];
                    else if (r < 65)
                        codes[i] = hkr_pkg::KEY_NONE;
                    else if (r < 90) begin
                        case ($urandom_range(5))
                            0, 1: codes[i] = hkr_pkg::KEY_A + 8'($urandom_range(25));
                            2:    codes[i] = hkr_pkg::KEY_1 + 8'($urandom_range(9));
                            3:    codes[i] = ($urandom_range(2) == 0) ? hkr_pkg::KEY_ENTER :
                                             ($urandom_range(1) == 0) ? hkr_pkg::KEY_BACKSPACE :
                                             hkr_pkg::KEY_SPACE;
                            4:    codes[i] = $urandom_range(1) ? hkr_pkg::KEY_ARROW_UP :
                                             hkr_pkg::KEY_ARROW_DOWN;
                            default: codes[i] = 8'($urandom_range(8'h7F, 1));
                        endcase
                    end else
                        codes[i] = 8'($urandom_range(255));
                end
            end
            send_report(mods, codes);
            // Let the pipeline run dry once
            if (pause_midway && k == n / 2)
                wait_idle();
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        test_key_table();
        test_char_registers();
        test_random_typing(PHASE_REPORTS, 36, 78, 8'h00, 8'hFF, 8'($urandom_range(255)), 1'b1);
        test_random_typing(PHASE_REPORTS, 78, 36, 8'hFF, 8'h00, 8'h00, 1'b0);
        test_random_typing(PHASE_REPORTS, 0, 0, 8'($urandom_range(255)),
                           8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
        wait_idle();
        repeat (4) @(posedge aclk);
        if (expected_keys.size() != 0)
            report_mismatch("results never delivered", 0, expected_keys.size());
        $display("covered %0d reports, %0d results (%0d with a character), %0d register writes",
                 n_reports, n_results, n_chars, n_writes);
        $display("three stall profiles, zeroed and saturated characters, %0d mismatches", errors);
        if (errors == 0)
            $display("hid_keyboard_report_to_ascii_core regression: pass");
        else
            $display("hid_keyboard_report_to_ascii_core regression: fail");
        $finish;
    end

endmodule
